// ----- sv/swsnd_pkg.sv -----
// Shared types and constants of the sliding-window sender.
package swsnd_pkg;

    localparam int WINDOW_LIMIT_DEF = 4;
    localparam int OP_W             = 2;
    localparam int SEQ_W            = 16;
    localparam int STATION_W        = 8;
    localparam int WIN_OUT_W        = 3;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MY_STATION   = CFG_IDX_W'(1);

    localparam logic [SEQ_W-1:0]     TOTAL_FRAMES_RST = SEQ_W'(1);
    localparam logic [STATION_W-1:0] MY_STATION_RST   = STATION_W'(0);

    typedef enum logic [OP_W-1:0] {
        OP_ACK     = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_SEND    = 2'd2
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [SEQ_W-1:0]     ack_seq;
        logic [STATION_W-1:0] ack_dest;
    } t_item;

    typedef struct packed {
        logic                 send_valid;
        logic [SEQ_W-1:0]     send_seq;
        logic [SEQ_W-1:0]     acked_through;
        logic [WIN_OUT_W-1:0] window_size;
        logic                 done_res;
    } t_result;

endpackage

// ----- sv/swsnd_in_if.sv -----
// Event channel into the sender.
interface swsnd_in_if;
    logic                            valid;
    logic                            ready;
    logic [swsnd_pkg::OP_W-1:0]      operation;
    logic [swsnd_pkg::SEQ_W-1:0]     ack_seq;
    logic [swsnd_pkg::STATION_W-1:0] ack_dest;

    modport source (output valid, operation, ack_seq, ack_dest, input ready);
    modport sink   (input valid, operation, ack_seq, ack_dest, output ready);
endinterface

// ----- sv/swsnd_out_if.sv -----
// Result channel out of the sender.
interface swsnd_out_if;
    logic                            valid;
    logic                            ready;
    logic                            send_valid;
    logic [swsnd_pkg::SEQ_W-1:0]     send_seq;
    logic [swsnd_pkg::SEQ_W-1:0]     acked_through;
    logic [swsnd_pkg::WIN_OUT_W-1:0] window_size;
    logic                            done_res;

    modport source (output valid, send_valid, send_seq, acked_through, window_size,
                    done_res, input ready);
    modport sink   (input valid, send_valid, send_seq, acked_through, window_size,
                    done_res, output ready);
endinterface

// ----- sv/swsnd_window.sv -----
// Window state, configuration registers and the per-event update logic.
module swsnd_window #(
    parameter int WINDOW_LIMIT = swsnd_pkg::WINDOW_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [swsnd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [swsnd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_step,
    input  swsnd_pkg::t_item                    i_item,
    output swsnd_pkg::t_result                  o_result
);

    localparam int CW = $clog2(WINDOW_LIMIT + 1);
    localparam int BW = WINDOW_LIMIT;
    localparam int TW = $clog2(BW + 1);
    localparam int SW = swsnd_pkg::SEQ_W;
    localparam int OW = swsnd_pkg::WIN_OUT_W;

    logic [SW-1:0]                   r_total_frames;
    logic [swsnd_pkg::STATION_W-1:0] r_my_station;
    logic [SW-1:0]                   r_window_base, n_window_base;
    logic [SW-1:0]                   r_next_frame, n_next_frame;
    logic [CW-1:0]                   r_cur_window, n_cur_window;
    logic [BW-1:0]                   r_pending, n_pending;
    logic                            r_finished, n_finished;

    swsnd_pkg::t_op w_op;
    logic           w_ack_ok;
    logic [SW-1:0]  w_offset;
    logic [BW-1:0]  w_shifted;
    logic [TW-1:0]  w_trail;
    logic           w_run;
    logic [SW-1:0]  w_adv_base;
    logic [SW-1:0]  w_diff;
    logic           w_send_ok;
    logic [CW-1:0]  w_half;
    logic           w_sent;
    logic [SW-1:0]  w_sent_seq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_frames <= swsnd_pkg::TOTAL_FRAMES_RST;
            r_my_station   <= swsnd_pkg::MY_STATION_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swsnd_pkg::CFG_TOTAL_FRAMES: r_total_frames <= i_cfg_data;
                swsnd_pkg::CFG_MY_STATION:
                    r_my_station <= i_cfg_data[swsnd_pkg::STATION_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_op      = swsnd_pkg::t_op'(i_item.operation);
    assign w_ack_ok  = (i_item.ack_dest == r_my_station) && (i_item.ack_seq != '0) &&
                       (i_item.ack_seq <= r_total_frames) &&
                       (i_item.ack_seq > r_window_base);
    assign w_offset  = i_item.ack_seq - r_window_base - SW'(1);
    assign w_shifted = r_pending >> 1;

    // Length of the run of early acknowledgments that follow the new base.
    always_comb begin
        w_run   = 1'b1;
        w_trail = '0;
        for (int i = 0; i < BW; i++) begin
            if (w_run && w_shifted[i]) begin
                w_trail = w_trail + TW'(1);
            end else begin
                w_run = 1'b0;
            end
        end
    end

    assign w_adv_base = r_window_base + SW'(1) + SW'(w_trail);
    assign w_diff     = r_next_frame - r_window_base;
    assign w_send_ok  = (r_next_frame < r_total_frames) && (r_next_frame >= r_window_base) &&
                        (w_diff < SW'(r_cur_window));
    assign w_half     = (r_cur_window >> 1) == '0 ? CW'(1) : (r_cur_window >> 1);

    always_comb begin
        n_window_base = r_window_base;
        n_next_frame  = r_next_frame;
        n_cur_window  = r_cur_window;
        n_pending     = r_pending;
        n_finished    = r_finished;
        w_sent        = 1'b0;
        w_sent_seq    = '0;
        if (!r_finished) begin
            case (w_op)
                swsnd_pkg::OP_ACK: begin
                    if (w_ack_ok) begin
                        if (w_offset == '0) begin
                            if (r_cur_window < CW'(WINDOW_LIMIT)) begin
                                n_cur_window = r_cur_window + CW'(1);
                            end
                            n_window_base = w_adv_base;
                            n_pending     = w_shifted >> w_trail;
                            if (r_next_frame < w_adv_base) begin
                                n_next_frame = w_adv_base;
                            end
                            if (w_adv_base >= r_total_frames) begin
                                n_finished = 1'b1;
                            end
                        end else if (w_offset < SW'(WINDOW_LIMIT)) begin
                            n_pending = r_pending | (BW'(1) << w_offset);
                        end
                    end
                end
                swsnd_pkg::OP_TIMEOUT: begin
                    n_cur_window = w_half;
                    n_pending    = '0;
                    n_next_frame = r_window_base;
                end
                swsnd_pkg::OP_SEND: begin
                    if (w_send_ok) begin
                        w_sent       = 1'b1;
                        w_sent_seq   = r_next_frame + SW'(1);
                        n_next_frame = r_next_frame + SW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_base <= '0;
            r_next_frame  <= '0;
            r_cur_window  <= CW'(WINDOW_LIMIT);
            r_pending     <= '0;
            r_finished    <= 1'b0;
        end else if (i_step) begin
            r_window_base <= n_window_base;
            r_next_frame  <= n_next_frame;
            r_cur_window  <= n_cur_window;
            r_pending     <= n_pending;
            r_finished    <= n_finished;
        end
    end

    assign o_result.send_valid    = w_sent;
    assign o_result.send_seq      = w_sent_seq;
    assign o_result.acked_through = n_window_base;
    assign o_result.window_size   = OW'(n_cur_window);
    assign o_result.done_res      = n_finished;

`ifndef NO_ASSERTIONS
    // The window stays between one frame and the limit.
    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_window != '0) && (r_cur_window <= CW'(WINDOW_LIMIT)))
        else $error("window size out of range");

    // The frame right after the base is never held as an early acknowledgment.
    a_no_head_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pending[0])
        else $error("early acknowledgment held for the base frame");

    // The base only moves forward.
    a_base_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_window_base >= $past(r_window_base))
        else $error("window base moved backward");

    // After completion the window state is frozen.
    a_finished_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished && $stable(r_window_base) && $stable(r_next_frame) &&
                       $stable(r_cur_window))
        else $error("state changed after completion");
`endif

endmodule

// ----- sv/sliding_window_sender.sv -----
// Top level of the sliding-window sender: input register, window logic, result register.
//
// Usage:
//   Events enter on i_in: operation 0 is an acknowledgment (ack_seq, ack_dest),
//   1 a retransmit timeout, 2 a send opportunity. Every event yields exactly one
//   item on o_out with the send decision and the window state after the event.
//   Configuration (total_frames at index 0, my_station at index 1) is written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no event is in flight.
// Timing:
//   An accepted event waits in the input register, is evaluated by the window
//   logic and its result is registered and offered on o_out. The window update is a
//   single pass of logic, so one event is taken every cycle while o_out is not stalled.
// Reset:
//   i_rst_n is synchronous and active low. It empties both registers, sets the
//   window to WINDOW_LIMIT, clears the base, send pointer and early
//   acknowledgments, and restores total_frames to 1 and my_station to 0.
// Stall:
//   While o_out is stalled the result register holds; one more event may wait in
//   the input register, after which i_in.ready drops until the result is taken.
module sliding_window_sender #(
    parameter int WINDOW_LIMIT = swsnd_pkg::WINDOW_LIMIT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swsnd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swsnd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swsnd_in_if.sink                         i_in,
    swsnd_out_if.source                      o_out
);

    logic               r_in_valid;
    swsnd_pkg::t_item   r_in_item;
    logic               r_out_valid;
    swsnd_pkg::t_result r_out_result;
    logic               w_adv;
    logic               w_step;
    swsnd_pkg::t_result w_result;

    assign w_adv      = !r_out_valid || o_out.ready;
    assign w_step     = r_in_valid && w_adv;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item.operation <= i_in.operation;
            r_in_item.ack_seq   <= i_in.ack_seq;
            r_in_item.ack_dest  <= i_in.ack_dest;
        end
        if (w_step) begin
            r_out_result <= w_result;
        end
    end

    swsnd_window #(
        .WINDOW_LIMIT (WINDOW_LIMIT)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_step),
        .i_item     (r_in_item),
        .o_result   (w_result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.send_valid    = r_out_result.send_valid;
    assign o_out.send_seq      = r_out_result.send_seq;
    assign o_out.acked_through = r_out_result.acked_through;
    assign o_out.window_size   = r_out_result.window_size;
    assign o_out.done_res      = r_out_result.done_res;

`ifndef NO_ASSERTIONS
    // A waiting event is neither lost nor overwritten while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_item))
        else $error("pending event lost during stall");

    // Every evaluated event lands in the result register.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("evaluated event produced no result");
`endif

endmodule
